// ===== sv/etrm_pkg.sv =====
// Package: shared types, constants and the CORDIC arc table for the rotation matrix block.
`default_nettype none
package etrm_pkg;

  localparam int ANGLE_WIDTH_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS       = 30;
  localparam int CORDIC_FRAC        = 30;
  localparam int CORDIC_W           = 34;
  localparam int ZW                 = 34;
  localparam int FIELD_W            = 16;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INIT = 34'sd652032874;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m22;
  } out_item_t;

  function automatic logic signed [ZW-1:0] arc(input int i);
    logic signed [ZW-1:0] t;
    begin
      case (i)
        0: t = 34'sd536870912;   1: t = 34'sd316933406;
        2: t = 34'sd167458907;   3: t = 34'sd85004756;
        4: t = 34'sd42667331;    5: t = 34'sd21354465;
        6: t = 34'sd10679838;    7: t = 34'sd5340245;
        8: t = 34'sd2670163;     9: t = 34'sd1335087;
        10: t = 34'sd667544;     11: t = 34'sd333772;
        12: t = 34'sd166886;     13: t = 34'sd83443;
        14: t = 34'sd41721;      15: t = 34'sd20860;
        16: t = 34'sd10430;      17: t = 34'sd5215;
        18: t = 34'sd2607;       19: t = 34'sd1303;
        20: t = 34'sd651;        21: t = 34'sd325;
        22: t = 34'sd162;        23: t = 34'sd81;
        24: t = 34'sd40;         25: t = 34'sd20;
        26: t = 34'sd10;         27: t = 34'sd5;
        28: t = 34'sd2;          29: t = 34'sd1;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/etrm_cordic.sv =====
// Pipelined rotation-mode CORDIC: one step per stage, quadrant fold and rounding at the end.
`default_nettype none
module etrm_cordic #(
  parameter int ANGLE_WIDTH    = etrm_pkg::ANGLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = etrm_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic [ANGLE_WIDTH-1:0]      angle,
  output logic signed [COEF_FRAC_BITS+1:0] cos_out,
  output logic signed [COEF_FRAC_BITS+1:0] sin_out
);
  localparam int N  = etrm_pkg::CORDIC_STEPS;
  localparam int W  = etrm_pkg::CORDIC_W;
  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int SH = etrm_pkg::CORDIC_FRAC - COEF_FRAC_BITS;
  localparam logic signed [W-1:0] ONE_W = W'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [W-1:0] HALF  = W'(1) <<< (SH - 1);

  logic signed [W-1:0] x_r [N+1];
  logic signed [W-1:0] y_r [N+1];
  logic signed [W-1:0] z_r [N+1];
  logic [1:0]          q_r [N+1];
  logic [ANGLE_WIDTH-3:0] r_in;
  logic signed [W-1:0] xr, yr, cc, ss;
  logic signed [CW-1:0] c_r, s_r;
  logic [1:0] qf_r;

  assign r_in = angle[ANGLE_WIDTH-3:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= etrm_pkg::CORDIC_GAIN_INIT;
      y_r[0] <= '0;
      z_r[0] <= W'({r_in, {(32-ANGLE_WIDTH){1'b0}}});
      q_r[0] <= angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - etrm_pkg::arc(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + etrm_pkg::arc(i);
        end
      end
    end
  end

  always_comb begin
    xr = (x_r[N] + HALF) >>> SH;
    yr = (y_r[N] + HALF) >>> SH;
    cc = (xr > ONE_W) ? ONE_W : ((xr < -ONE_W) ? -ONE_W : xr);
    ss = (yr > ONE_W) ? ONE_W : ((yr < -ONE_W) ? -ONE_W : yr);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r  <= CW'(cc);
      s_r  <= CW'(ss);
      qf_r <= q_r[N];
    end
  end

  always_comb begin
    case (qf_r)
      2'd0: begin cos_out = c_r;  sin_out = s_r;  end
      2'd1: begin cos_out = -s_r; sin_out = c_r;  end
      2'd2: begin cos_out = -c_r; sin_out = -s_r; end
      default: begin cos_out = s_r; sin_out = -c_r; end
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/euler_to_rotation_matrix.sv =====
// Pipeline: 31 CORDIC stages, 1 fold stage and 4 matrix stages from input transaction to result.
// Throughput: one transaction per cycle; the whole pipeline advances when the output is free.
// An input transaction is taken whenever the output register is empty or being drained.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
`default_nettype none
module euler_to_rotation_matrix #(
  parameter int ANGLE_WIDTH    = etrm_pkg::ANGLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = etrm_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire etrm_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output etrm_pkg::out_item_t     out_data
);
  localparam int F   = COEF_FRAC_BITS;
  localparam int CW  = F + 2;
  localparam int PW  = 2 * CW;
  localparam int SW  = PW + 2;
  localparam int LAT = etrm_pkg::CORDIC_STEPS + 6;
  localparam logic signed [SW-1:0] ONE_S  = SW'(1) <<< F;
  localparam logic signed [SW-1:0] HALF_S = SW'(1) <<< (F - 1);

  logic adv;
  logic [LAT-1:0] v_r;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  logic signed [CW-1:0] cr, sr, cp, sp, cy, sy;

  etrm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .COEF_FRAC_BITS(F)) u_roll (
    .clk(clk), .adv(adv), .angle(ANGLE_WIDTH'(in_data.roll_angle)),
    .cos_out(cr), .sin_out(sr));
  etrm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .COEF_FRAC_BITS(F)) u_pitch (
    .clk(clk), .adv(adv), .angle(ANGLE_WIDTH'(in_data.pitch_angle)),
    .cos_out(cp), .sin_out(sp));
  etrm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .COEF_FRAC_BITS(F)) u_yaw (
    .clk(clk), .adv(adv), .angle(ANGLE_WIDTH'(in_data.yaw_angle)),
    .cos_out(cy), .sin_out(sy));

  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [SW-1:0] p);
    logic signed [SW-1:0] t;
    begin
      t = (p + HALF_S) >>> F;
      if (t > ONE_S) t = ONE_S;
      else if (t < -ONE_S) t = -ONE_S;
      return CW'(t);
    end
  endfunction

  // stage A: inner products
  logic signed [PW-1:0] spsr_p_r, spcr_p_r, cpsr_p_r, cpcr_p_r;
  logic signed [CW-1:0] a_cr_r, a_sr_r, a_cp_r, a_sp_r, a_cy_r, a_sy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      spsr_p_r <= sp * sr; spcr_p_r <= sp * cr;
      cpsr_p_r <= cp * sr; cpcr_p_r <= cp * cr;
      a_cr_r <= cr; a_sr_r <= sr; a_cp_r <= cp;
      a_sp_r <= sp; a_cy_r <= cy; a_sy_r <= sy;
    end
  end

  // stage B: round inner products
  logic signed [CW-1:0] spsr_r, spcr_r, cpsr_r, cpcr_r;
  logic signed [CW-1:0] b_cr_r, b_sr_r, b_cp_r, b_sp_r, b_cy_r, b_sy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      spsr_r <= rnd_sat(SW'(spsr_p_r)); spcr_r <= rnd_sat(SW'(spcr_p_r));
      cpsr_r <= rnd_sat(SW'(cpsr_p_r)); cpcr_r <= rnd_sat(SW'(cpcr_p_r));
      b_cr_r <= a_cr_r; b_sr_r <= a_sr_r; b_cp_r <= a_cp_r;
      b_sp_r <= a_sp_r; b_cy_r <= a_cy_r; b_sy_r <= a_sy_r;
    end
  end

  // stage C: outer products
  logic signed [PW-1:0] p0a_r, p0b_r, p1_r, p2a_r, p2b_r, p3a_r, p3b_r, p4_r, p5a_r, p5b_r;
  logic signed [CW-1:0] c_cpsr_r, c_sp_r, c_cpcr_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p0a_r <= b_cy_r * b_cr_r; p0b_r <= b_sy_r * spsr_r;
      p1_r  <= b_sy_r * b_cp_r;
      p2a_r <= b_sy_r * spcr_r; p2b_r <= b_cy_r * b_sr_r;
      p3a_r <= b_sy_r * b_cr_r; p3b_r <= b_cy_r * spsr_r;
      p4_r  <= b_cy_r * b_cp_r;
      p5a_r <= b_sy_r * b_sr_r; p5b_r <= b_cy_r * spcr_r;
      c_cpsr_r <= cpsr_r; c_sp_r <= b_sp_r; c_cpcr_r <= cpcr_r;
    end
  end

  // stage D: sums, rounding, saturation into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.m00 <= 16'(rnd_sat(SW'(p0a_r) + SW'(p0b_r)));
      out_data.m01 <= 16'(rnd_sat(-SW'(p1_r)));
      out_data.m02 <= 16'(rnd_sat(SW'(p2a_r) - SW'(p2b_r)));
      out_data.m10 <= 16'(rnd_sat(SW'(p3a_r) - SW'(p3b_r)));
      out_data.m11 <= 16'(rnd_sat(SW'(p4_r)));
      out_data.m12 <= 16'(rnd_sat(-SW'(p5a_r) - SW'(p5b_r)));
      out_data.m20 <= 16'(c_cpsr_r);
      out_data.m21 <= 16'(c_sp_r);
      out_data.m22 <= 16'(c_cpcr_r);
    end
  end
endmodule
`default_nettype wire

// ===== sv/etrm_checker.sv =====
// Port-level checker for the rotation matrix block, bound to the top level.
`default_nettype none
module etrm_props (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire etrm_pkg::out_item_t out_data
);
  a_stall_only_when_out_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("input stalled without output stall");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
  a_m21_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.m21 <= 16'sd16384 && out_data.m21 >= -16'sd16384))
    else $error("entry out of range");
  a_m00_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.m00 <= 16'sd16384 && out_data.m00 >= -16'sd16384))
    else $error("entry out of range");
endmodule

bind euler_to_rotation_matrix etrm_props u_etrm_props (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire
